FILE: src/lgf_pkg.sv
// Shared widths, constants and controller/datapath handshake structs for the gap filler.
package lgf_pkg;

   localparam int VAL_W     = 32;
   localparam int CNT_W     = 6;
   localparam int CNT_MAX   = (1 << CNT_W) - 1;
   localparam int GDIV_W    = CNT_W + 1;
   localparam int ACC_W     = VAL_W + 1 + CNT_W;
   localparam int MAG_W     = ACC_W - 1;
   localparam int DIV_STEPS = MAG_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic put;
   } lgf_cmd_type;

   typedef struct packed {
      logic fill_left;
      logic interp;
      logic div_last;
      logic out_free;
      logic rest_only;
   } lgf_status_type;

endpackage

FILE: src/lgf_req_if.sv
// Input channel carrying one series sample per item.
interface lgf_req_if;
   import lgf_pkg::*;

   logic               valid;
   logic               ready;
   logic signed [VAL_W-1:0] sample;
   logic               missing;
   logic               end_of_series;

   modport source (output valid, output sample, output missing, output end_of_series,
                   input ready);
   modport sink   (input valid, input sample, input missing, input end_of_series,
                   output ready);
endinterface

FILE: src/lgf_rsp_if.sv
// Result channel carrying one filled or passed sample per item.
interface lgf_rsp_if;
   import lgf_pkg::*;

   logic               valid;
   logic               ready;
   logic signed [VAL_W-1:0] value;
   logic               still_missing;
   logic               overflow;
   logic               last_of_series;

   modport source (output valid, output value, output still_missing, output overflow,
                   output last_of_series, input ready);
   modport sink   (input valid, input value, input still_missing, input overflow,
                   input last_of_series, output ready);
endinterface

FILE: src/linear_gap_fill_top.sv
// Top level of the linear gap filler: controller, datapath and channel wiring.
//
// Fills gaps in a stream of series by linear interpolation, one input item per
// sample. A missing sample inside a series is absorbed and gives no result. A
// valid sample after a gap of n samples gives n + 1 results. Once the item is
// accepted, each interpolated result passes through one set-up state, the
// one-bit-per-cycle restoring divider and the load of the output register, while
// copied and passed results need only the set-up state and the load. The divider
// is the limiting unit. Gaps longer than MAX_GAP (at most 63) saturate, and every
// result of that gap carries overflow. One output register parts the two sides,
// so the next item can be taken while the last result of the previous one still
// waits.
module linear_gap_fill_top #(
   parameter int MAX_GAP = 63
) (
   input  logic        clock,
   input  logic        reset,
   lgf_req_if.sink     req_chan,
   lgf_rsp_if.source   rsp_chan
);
   import lgf_pkg::*;

   localparam int GapLimit = (MAX_GAP < CNT_MAX) ? MAX_GAP : CNT_MAX;

   lgf_cmd_type    cmd;
   lgf_status_type status;

   lgf_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_missing       (req_chan.missing),
      .req_end_of_series (req_chan.end_of_series),
      .status            (status),
      .cmd               (cmd)
   );

   lgf_dp #(
      .GAP_LIMIT (GapLimit)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_sample         (req_chan.sample),
      .req_missing        (req_chan.missing),
      .req_end_of_series  (req_chan.end_of_series),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_value          (rsp_chan.value),
      .rsp_still_missing  (rsp_chan.still_missing),
      .rsp_overflow       (rsp_chan.overflow),
      .rsp_last_of_series (rsp_chan.last_of_series)
   );

endmodule

FILE: src/lgf_ctrl.sv
// Controller state machine sequencing accept, division and result loading.
module lgf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_missing,
   input  logic                    req_end_of_series,
   input  lgf_pkg::lgf_status_type status,
   output lgf_pkg::lgf_cmd_type    cmd
);
   import lgf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_NEXT = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_PUT  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               // A missing sample inside a series only lengthens the gap, or flags overflow once the gap is saturated.
               if (!req_missing || req_end_of_series) begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            if (status.fill_left && status.interp) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (status.out_free) begin
               cmd.put  = 1'b1;
               state_in = status.rest_only ? ST_IDLE : ST_NEXT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/lgf_dp.sv
// Datapath: series state, product accumulator, restoring divider and output register.
module lgf_dp #(
   parameter int GAP_LIMIT = 63
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lgf_pkg::lgf_cmd_type           cmd,
   output lgf_pkg::lgf_status_type        status,
   input  logic signed [lgf_pkg::VAL_W-1:0] req_sample,
   input  logic                           req_missing,
   input  logic                           req_end_of_series,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [lgf_pkg::VAL_W-1:0] rsp_value,
   output logic                           rsp_still_missing,
   output logic                           rsp_overflow,
   output logic                           rsp_last_of_series
);
   import lgf_pkg::*;

   localparam logic [CNT_W-1:0] LIMIT = CNT_W'(GAP_LIMIT);

   // Series state.
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [VAL_W-1:0] last_ff, last_in;
   logic                    seen_ff, seen_in;
   logic                    ovf_ff, ovf_in;

   // Current item and gap walk.
   logic signed [VAL_W-1:0] samp_ff;
   logic                    miss_ff;
   logic                    eos_ff;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic signed [VAL_W:0]   diff_ff;
   logic signed [ACC_W-1:0] acc_ff;

   // Divider.
   logic [MAG_W-1:0]        quo_ff;
   logic [GDIV_W-1:0]       rem_ff;
   logic [STEP_W-1:0]       step_ff;
   logic                    neg_ff;

   // Output register.
   logic                    out_valid_ff;
   logic signed [VAL_W-1:0] out_value_ff;
   logic                    out_miss_ff;
   logic                    out_ovf_ff;
   logic                    out_last_ff;

   logic signed [VAL_W:0]   diff_new;
   logic signed [ACC_W-1:0] acc_abs;
   logic [GDIV_W-1:0]       divisor;
   logic [GDIV_W-1:0]       trial;
   logic                    trial_ge;
   logic [VAL_W-1:0]        quo_signed;
   logic                    fill_left;
   logic                    gap_end;
   logic                    final_res;
   logic signed [VAL_W-1:0] res_value;
   logic                    res_miss;
   logic                    res_last;

   assign diff_new   = {req_sample[VAL_W-1], req_sample} - {last_ff[VAL_W-1], last_ff};
   assign acc_abs    = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
   assign divisor    = {1'b0, cnt_ff} + GDIV_W'(1);
   assign trial      = {rem_ff[GDIV_W-2:0], quo_ff[MAG_W-1]};
   assign trial_ge   = (trial >= divisor);
   assign quo_signed = neg_ff ? -quo_ff[VAL_W-1:0] : quo_ff[VAL_W-1:0];

   assign fill_left = (idx_ff != cnt_ff);
   assign gap_end   = (idx_ff == cnt_ff - CNT_W'(1));
   assign final_res = fill_left ? (miss_ff && gap_end) : 1'b1;

   always_comb begin
      res_value = samp_ff;
      res_miss  = 1'b0;
      res_last  = fill_left ? (miss_ff && gap_end) : eos_ff;
      if (fill_left) begin
         if (seen_ff && !miss_ff) begin
            res_value = last_ff + $signed(quo_signed);
         end else if (seen_ff) begin
            res_value = last_ff;
         end else if (miss_ff) begin
            // Nothing valid in the whole series.
            res_value = '0;
            res_miss  = 1'b1;
         end
      end
   end

   assign status.fill_left = fill_left;
   assign status.interp    = seen_ff && !miss_ff;
   assign status.div_last  = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign status.out_free  = !out_valid_ff || rsp_ready;
   assign status.rest_only = final_res;

   always_comb begin
      cnt_in  = cnt_ff;
      last_in = last_ff;
      seen_in = seen_ff;
      ovf_in  = ovf_ff;
      idx_in  = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
         if (req_missing) begin
            if (cnt_ff < LIMIT) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
      if (cmd.put) begin
         if (final_res) begin
            if (eos_ff) begin
               last_in = '0;
               seen_in = 1'b0;
            end else begin
               last_in = samp_ff;
               seen_in = 1'b1;
            end
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
         seen_ff <= seen_in;
         ovf_ff  <= ovf_in;
         idx_ff  <= idx_in;
         if (cmd.put) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         samp_ff <= req_sample;
         miss_ff <= req_missing;
         eos_ff  <= req_end_of_series;
         diff_ff <= diff_new;
         acc_ff  <= ACC_W'(diff_new);
      end else if (cmd.put) begin
         // The accumulator holds (index + 1) times the step across the gap.
         acc_ff <= acc_ff + ACC_W'(diff_ff);
      end
      if (cmd.div_start) begin
         quo_ff  <= acc_abs[MAG_W-1:0];
         rem_ff  <= '0;
         step_ff <= '0;
         neg_ff  <= acc_ff[ACC_W-1];
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[MAG_W-2:0], trial_ge};
         rem_ff  <= trial_ge ? (trial - divisor) : trial;
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.put) begin
         out_value_ff <= res_value;
         out_miss_ff  <= res_miss;
         out_ovf_ff   <= ovf_ff;
         out_last_ff  <= res_last;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_value          = out_value_ff;
   assign rsp_still_missing  = out_miss_ff;
   assign rsp_overflow       = out_ovf_ff;
   assign rsp_last_of_series = out_last_ff;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the linear gap filler: directed table, random series, scoreboard.
`timescale 1ns / 1ps

module tb;
   import lgf_pkg::*;

   localparam int FILL_GAP      = 63;
   localparam int GAP_LIMIT     = (FILL_GAP < CNT_MAX) ? FILL_GAP : CNT_MAX;
   localparam int RANDOM_ITEMS  = 75;
   localparam int FLUSH_CYCLES  = 200;
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    still_missing;
      logic                    overflow;
      logic                    last_of_series;
   } fill_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] sample;
      logic                    missing;
      logic                    end_of_series;
   } sample_type;

   // A typed row carries a fixed expectation: count copies of one value.
   typedef struct packed {
      logic                    typed;
      logic [7:0]              count;
      logic signed [VAL_W-1:0] value;
      logic                    still_missing;
   } note_type;

   typedef struct packed {
      sample_type item;
      note_type   note;
   } row_type;

   logic clock = 1'b0;
   logic reset;
   logic calm = 1'b0;
   int   mismatch_count = 0;

   lgf_req_if req_chan ();
   lgf_rsp_if rsp_chan ();

   linear_gap_fill_top #(
      .MAX_GAP (FILL_GAP)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow state of the filler.
   logic [CNT_W-1:0]        held_count;
   logic signed [VAL_W-1:0] last_good;
   logic                    have_valid;
   logic                    gap_over;

   fill_type   step_out[$];
   fill_type   expected_fills[$];
   note_type   item_notes[$];
   row_type    directed_rows[$];
   sample_type series_items[$];

   function automatic void clear_fill_state();
      held_count = '0;
      last_good  = '0;
      have_valid = 1'b0;
      gap_over   = 1'b0;
   endfunction

   // Works out the results of one accepted item into step_out and advances the state.
   function automatic void interpolate_item(sample_type it);
      fill_type r;
      logic     ovf;
      longint   span;
      longint   gdiv;
      longint   fill_val;
      int       i;
      step_out.delete();
      ovf = gap_over;
      if (it.missing) begin
         if (held_count < GAP_LIMIT) held_count = held_count + 1'b1;
         else gap_over = 1'b1;
         if (!it.end_of_series) return;
         for (i = 0; i < held_count; i++) begin
            r.value          = have_valid ? last_good : '0;
            r.still_missing  = !have_valid;
            r.overflow       = gap_over;
            r.last_of_series = (i == held_count - 1);
            step_out.push_back(r);
         end
         clear_fill_state();
         return;
      end
      gdiv = longint'(held_count) + 1;
      span = longint'(it.sample) - longint'(last_good);
      for (i = 1; i <= held_count; i++) begin
         // Division of longint truncates toward zero, as the divider does.
         fill_val         = have_valid ? longint'(last_good) + (longint'(i) * span) / gdiv
                                       : longint'(it.sample);
         r.value          = fill_val[VAL_W-1:0];
         r.still_missing  = 1'b0;
         r.overflow       = ovf;
         r.last_of_series = 1'b0;
         step_out.push_back(r);
      end
      r.value          = it.sample;
      r.still_missing  = 1'b0;
      r.overflow       = ovf;
      r.last_of_series = it.end_of_series;
      step_out.push_back(r);
      if (it.end_of_series) begin
         clear_fill_state();
      end else begin
         last_good  = it.sample;
         have_valid = 1'b1;
         held_count = '0;
         gap_over   = 1'b0;
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      sample_type it;
      note_type   nt;
      fill_type   r;
      fill_type   want;
      int         k;
      if (reset) begin
         clear_fill_state();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            it.sample        = req_chan.sample;
            it.missing       = req_chan.missing;
            it.end_of_series = req_chan.end_of_series;
            nt = (item_notes.size() > 0) ? item_notes.pop_front() : '0;
            interpolate_item(it);
            if (nt.typed) begin
               for (k = 0; k < nt.count; k++) begin
                  r.value          = nt.value;
                  r.still_missing  = nt.still_missing;
                  r.overflow       = 1'b0;
                  r.last_of_series = it.end_of_series && (k == nt.count - 1);
                  expected_fills.push_back(r);
               end
            end else begin
               foreach (step_out[k]) expected_fills.push_back(step_out[k]);
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_fills.size() == 0) begin
               $error("unexpected result: value %0d", rsp_chan.value);
               mismatch_count++;
            end else begin
               want = expected_fills.pop_front();
               if (rsp_chan.value !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, rsp_chan.value);
                  mismatch_count++;
               end
               if (rsp_chan.still_missing !== want.still_missing) begin
                  $error("still_missing: expected %0b, got %0b", want.still_missing,
                         rsp_chan.still_missing);
                  mismatch_count++;
               end
               if (rsp_chan.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_chan.overflow);
                  mismatch_count++;
               end
               if (rsp_chan.last_of_series !== want.last_of_series) begin
                  $error("last_of_series: expected %0b, got %0b", want.last_of_series,
                         rsp_chan.last_of_series);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // The sink stalls in bursts until the closing stretch of the run.
   initial begin
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   // Valid is only lowered when a gap is taken, so it never toggles within one step.
   task automatic send_sample(sample_type it, note_type nt);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      item_notes.push_back(nt);
      req_chan.valid         <= 1'b1;
      req_chan.sample        <= it.sample;
      req_chan.missing       <= it.missing;
      req_chan.end_of_series <= it.end_of_series;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic void add_row(logic signed [VAL_W-1:0] sample, logic miss, logic eos,
                                   logic typed, int count, logic signed [VAL_W-1:0] value,
                                   logic still);
      row_type rw;
      rw.item.sample         = sample;
      rw.item.missing        = miss;
      rw.item.end_of_series  = eos;
      rw.note.typed          = typed;
      rw.note.count          = 8'(count);
      rw.note.value          = value;
      rw.note.still_missing  = still;
      directed_rows.push_back(rw);
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         case ($urandom_range(0, 3))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      if (r < 40) return $urandom_range(0, 200) - 100;
      return $urandom;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 12);
      return $urandom_range(GAP_LIMIT - 2, GAP_LIMIT + 4);
   endfunction

   function automatic void push_missing(int n);
      sample_type it;
      int         k;
      for (k = 0; k < n; k++) begin
         it.sample        = $urandom;
         it.missing       = 1'b1;
         it.end_of_series = 1'b0;
         series_items.push_back(it);
      end
   endfunction

   // Builds one series: mostly well formed, sometimes all missing or a stray item.
   function automatic void build_series(logic long_gap);
      sample_type it;
      int         r;
      int         segs;
      int         k;
      r = $urandom_range(0, 99);
      if (long_gap) begin
         series_items.push_back('{pick_sample(), 1'b0, 1'b0});
         push_missing(GAP_LIMIT + 3);
         series_items.push_back('{pick_sample(), 1'b0, 1'b0});
      end else if (r < 10) begin
         it.sample        = $urandom;
         it.missing       = 1'($urandom_range(0, 1));
         it.end_of_series = ($urandom_range(0, 3) == 0);
         series_items.push_back(it);
         return;
      end else if (r < 20) begin
         push_missing(pick_gap() + 1);
      end else begin
         segs = $urandom_range(1, 4);
         for (k = 0; k < segs; k++) begin
            push_missing(pick_gap());
            series_items.push_back('{pick_sample(), 1'b0, 1'b0});
         end
         if ($urandom_range(0, 9) < 3) push_missing(pick_gap());
      end
      it = series_items.pop_back();
      it.end_of_series = 1'b1;
      series_items.push_back(it);
   endfunction

   initial begin
      row_type    rw;
      sample_type it;
      int         random_sent;
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.sample        <= '0;
      req_chan.missing       <= 1'b0;
      req_chan.end_of_series <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Single-sample series, two of them at the extremes, and an all-missing one.
      add_row(7,            0, 1, 1, 1, 7,       0);
      add_row(VAL_MAX,      0, 1, 1, 1, VAL_MAX, 0);
      add_row(VAL_MIN,      0, 1, 1, 1, VAL_MIN, 0);
      add_row(32'h5A5A5A5A, 1, 1, 1, 1, 0,       1);
      // Leading gap copies the first valid sample.
      add_row('1,           1, 0, 1, 0, 0,       0);
      add_row(0,            1, 0, 1, 0, 0,       0);
      add_row(-3,           0, 1, 1, 3, -3,      0);
      // Inner gaps across the full range, then a trailing gap.
      add_row(VAL_MIN,      0, 0, 1, 1, VAL_MIN, 0);
      add_row(0,            1, 0, 1, 0, 0,       0);
      add_row(0,            1, 0, 1, 0, 0,       0);
      add_row(VAL_MAX,      0, 0, 0, 0, 0,       0);
      add_row(0,            1, 0, 1, 0, 0,       0);
      add_row(VAL_MIN,      0, 0, 0, 0, 0,       0);
      add_row(0,            1, 0, 1, 0, 0,       0);
      add_row(1,            1, 1, 1, 2, VAL_MIN, 0);
      // Falling and rising interpolation, where truncation toward zero matters, then a trailing gap.
      add_row(10,           0, 0, 1, 1, 10,      0);
      add_row(0,            1, 0, 1, 0, 0,       0);
      add_row(0,            1, 0, 1, 0, 0,       0);
      add_row(-10,          0, 1, 0, 0, 0,       0);
      add_row(-7,           0, 0, 1, 1, -7,      0);
      add_row(0,            1, 0, 1, 0, 0,       0);
      add_row(6,            0, 0, 0, 0, 0,       0);
      add_row(-1,           1, 0, 1, 0, 0,       0);
      add_row(6,            1, 1, 1, 2, 6,       0);

      foreach (directed_rows[k]) begin
         rw = directed_rows[k];
         send_sample(rw.item, rw.note);
      end

      random_sent = 0;
      build_series(1'b1);
      while (random_sent < RANDOM_ITEMS || series_items.size() > 0) begin
         if (series_items.size() == 0) build_series(1'b0);
         it = series_items.pop_front();
         send_sample(it, '0);
         random_sent++;
         if (random_sent > RANDOM_ITEMS * 3 / 4) calm <= 1'b1;
      end
      req_chan.valid <= 1'b0;

      while (expected_fills.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
